// ===== hdl/pss_pkg.sv =====
package pss_pkg;

  // lane counts of the two banks and of the merged network
  localparam int unsigned FIRST_LANES  = 8;
  localparam int unsigned SECOND_LANES = 4;
  localparam int unsigned HALF_LANES   = 4;
  localparam int unsigned LANE_IDX_W   = $clog2(FIRST_LANES);

  // configuration port geometry
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = COUNT_W;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SORT_ENABLE  = 3'd0,
    CFG_CHAIN_MODE   = 3'd1,
    CFG_FIRST_COUNT  = 3'd2,
    CFG_SECOND_COUNT = 3'd3
  } cfg_idx_t;

  // configuration state seen by the datapath
  typedef struct packed {
    logic               sort_enable;
    logic               chain_mode;
    logic [COUNT_W-1:0] first_count;
    logic [COUNT_W-1:0] second_count;
  } cfg_t;

  // odd-even merge network for eight lanes: six layers, nineteen compare-exchanges
  localparam int unsigned NET_STAGES = 6;

  // partner lane of each lane per layer; a lane paired with itself passes through
  localparam logic [LANE_IDX_W-1:0] NET_PARTNER [NET_STAGES][FIRST_LANES] = '{
    '{3'd1, 3'd0, 3'd3, 3'd2, 3'd5, 3'd4, 3'd7, 3'd6},
    '{3'd2, 3'd3, 3'd0, 3'd1, 3'd6, 3'd7, 3'd4, 3'd5},
    '{3'd0, 3'd2, 3'd1, 3'd3, 3'd4, 3'd6, 3'd5, 3'd7},
    '{3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3},
    '{3'd0, 3'd1, 3'd4, 3'd5, 3'd2, 3'd3, 3'd6, 3'd7},
    '{3'd0, 3'd2, 3'd1, 3'd4, 3'd3, 3'd6, 3'd5, 3'd7}
  };

  // bit i set: lane i keeps the smaller key of its pair
  localparam logic [FIRST_LANES-1:0] NET_TAKE_MIN [NET_STAGES] = '{
    8'b0101_0101,
    8'b0011_0011,
    8'b0010_0010,
    8'b0000_1111,
    8'b0000_1100,
    8'b0010_1010
  };

endpackage

// ===== hdl/pss_in_if.sv =====
interface pss_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] first_s0;
  logic signed [SAMPLE_BITS-1:0] first_s1;
  logic signed [SAMPLE_BITS-1:0] first_s2;
  logic signed [SAMPLE_BITS-1:0] first_s3;
  logic signed [SAMPLE_BITS-1:0] first_s4;
  logic signed [SAMPLE_BITS-1:0] first_s5;
  logic signed [SAMPLE_BITS-1:0] first_s6;
  logic signed [SAMPLE_BITS-1:0] first_s7;
  logic signed [SAMPLE_BITS-1:0] second_s0;
  logic signed [SAMPLE_BITS-1:0] second_s1;
  logic signed [SAMPLE_BITS-1:0] second_s2;
  logic signed [SAMPLE_BITS-1:0] second_s3;

  modport source (
    output valid, first_s0, first_s1, first_s2, first_s3,
           first_s4, first_s5, first_s6, first_s7,
           second_s0, second_s1, second_s2, second_s3,
    input  ready
  );

  modport sink (
    input  valid, first_s0, first_s1, first_s2, first_s3,
           first_s4, first_s5, first_s6, first_s7,
           second_s0, second_s1, second_s2, second_s3,
    output ready
  );
endinterface

// ===== hdl/pss_out_if.sv =====
interface pss_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_0;
  logic signed [SAMPLE_BITS-1:0] out_1;
  logic signed [SAMPLE_BITS-1:0] out_2;
  logic signed [SAMPLE_BITS-1:0] out_3;
  logic signed [SAMPLE_BITS-1:0] out_4;
  logic signed [SAMPLE_BITS-1:0] out_5;
  logic signed [SAMPLE_BITS-1:0] out_6;
  logic signed [SAMPLE_BITS-1:0] out_7;

  modport source (
    output valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
    input  ready
  );

  modport sink (
    input  valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
    output ready
  );
endinterface

// ===== hdl/pss_cfg_if.sv =====
interface pss_cfg_if
  import pss_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ===== hdl/pss_cfg_regs.sv =====
module pss_cfg_regs
  import pss_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  pss_cfg_if.sink cfg_ch,
  output cfg_t    cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // writes are always taken
  assign cfg_ch.ready = 1'b1;

  // register file decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_SORT_ENABLE:  cfg_nxt.sort_enable  = cfg_ch.data[0];
        CFG_CHAIN_MODE:   cfg_nxt.chain_mode   = cfg_ch.data[0];
        CFG_FIRST_COUNT:  cfg_nxt.first_count  = cfg_ch.data[COUNT_W-1:0];
        CFG_SECOND_COUNT: cfg_nxt.second_count = cfg_ch.data[COUNT_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sort_enable  <= 1'b0;
      cfg_r.chain_mode   <= 1'b1;
      cfg_r.first_count  <= '0;
      cfg_r.second_count <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/pss_key_prep.sv =====
module pss_key_prep
  import pss_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int KEY_W       = SAMPLE_BITS + 2
) (
  input  cfg_t                          cfg,
  input  logic signed [SAMPLE_BITS-1:0] first_smp  [FIRST_LANES],
  input  logic signed [SAMPLE_BITS-1:0] second_smp [SECOND_LANES],
  output logic signed [SAMPLE_BITS-1:0] lane_smp   [FIRST_LANES],
  output logic        [KEY_W-1:0]       lane_key   [FIRST_LANES]
);

  // key layout: {bank group, inactive, sample with sign bit flipped}
  // so an unsigned compare orders first bank before second, active before idle
  for (genvar i = 0; i < FIRST_LANES; i++) begin : g_lane
    logic grp;
    logic act;

    if (i < HALF_LANES) begin : g_low
      assign lane_smp[i] = first_smp[i];
      assign grp         = 1'b0;
      assign act         = cfg.first_count > COUNT_W'(i);
    end else begin : g_high
      // upper lanes carry first bank in chain mode, second bank otherwise
      assign lane_smp[i] = cfg.chain_mode ? first_smp[i] : second_smp[i-HALF_LANES];
      assign grp         = ~cfg.chain_mode;
      assign act         = cfg.chain_mode ? (cfg.first_count > COUNT_W'(i))
                                          : (cfg.second_count > COUNT_W'(i-HALF_LANES));
    end

    assign lane_key[i] = {grp, ~act, ~lane_smp[i][SAMPLE_BITS-1],
                          lane_smp[i][SAMPLE_BITS-2:0]};
  end

endmodule

// ===== hdl/pss_sort_net.sv =====
module pss_sort_net
  import pss_pkg::*;
#(
  parameter int KEY_W = 18
) (
  input  logic [KEY_W-1:0] key_in  [FIRST_LANES],
  output logic [KEY_W-1:0] key_out [FIRST_LANES]
);

  logic [KEY_W-1:0] lvl [NET_STAGES+1][FIRST_LANES];

  assign lvl[0] = key_in;

  // one compare-exchange layer per stage, each lane picks min or max of its pair
  for (genvar s = 0; s < NET_STAGES; s++) begin : g_stage
    for (genvar i = 0; i < FIRST_LANES; i++) begin : g_lane
      logic [KEY_W-1:0] mine;
      logic [KEY_W-1:0] other;
      logic             other_lt;

      assign mine     = lvl[s][i];
      assign other    = lvl[s][NET_PARTNER[s][i]];
      assign other_lt = other < mine;

      always_comb begin
        if (NET_TAKE_MIN[s][i]) begin
          lvl[s+1][i] = other_lt ? other : mine;
        end else begin
          lvl[s+1][i] = other_lt ? mine : other;
        end
      end
    end
  end

  assign key_out = lvl[NET_STAGES];

endmodule

// ===== hdl/poly_split_sort.sv =====
// Polyphonic split and sort: each input word is a frame of eight first-bank and four
// second-bank signed samples, and each frame gives one output word of eight samples.
// With sort off, outputs 0-3 carry first-bank samples 0-3 and outputs 4-7 carry
// first-bank samples 4-7 in chain mode, else second-bank samples 0-3. With sort on,
// the active samples of each bank (count saturated at 4, or 8 in chain mode) come out
// ascending and idle slots read zero. A frame is registered on entry, passes a
// six-layer compare-exchange network and is registered on exit; one frame is
// accepted every cycle while the output is taken. Write the configuration
// registers only while no frame is in flight.
module poly_split_sort
  import pss_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  pss_in_if.sink     in_ch,
  pss_out_if.source  out_ch,
  pss_cfg_if.sink    cfg_ch
);

  localparam int KEY_W = SAMPLE_BITS + 2;

  cfg_t cfg;

  logic s1_valid_r;
  logic s1_valid_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic in_take;
  logic out_load;

  logic signed [SAMPLE_BITS-1:0] first_r  [FIRST_LANES];
  logic signed [SAMPLE_BITS-1:0] second_r [SECOND_LANES];
  logic signed [SAMPLE_BITS-1:0] lane_smp [FIRST_LANES];
  logic        [KEY_W-1:0]       lane_key [FIRST_LANES];
  logic        [KEY_W-1:0]       sort_key [FIRST_LANES];
  logic signed [SAMPLE_BITS-1:0] res_nxt  [FIRST_LANES];
  logic signed [SAMPLE_BITS-1:0] res_r    [FIRST_LANES];

  // configuration registers
  pss_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // pipeline handshake
  assign out_load     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || out_load;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = in_take ? 1'b1 : (out_load ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_take) begin
      first_r[0]  <= in_ch.first_s0;
      first_r[1]  <= in_ch.first_s1;
      first_r[2]  <= in_ch.first_s2;
      first_r[3]  <= in_ch.first_s3;
      first_r[4]  <= in_ch.first_s4;
      first_r[5]  <= in_ch.first_s5;
      first_r[6]  <= in_ch.first_s6;
      first_r[7]  <= in_ch.first_s7;
      second_r[0] <= in_ch.second_s0;
      second_r[1] <= in_ch.second_s1;
      second_r[2] <= in_ch.second_s2;
      second_r[3] <= in_ch.second_s3;
    end
  end

  // lane routing and sort keys
  pss_key_prep #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .KEY_W       (KEY_W)
  ) u_prep (
    .cfg        (cfg),
    .first_smp  (first_r),
    .second_smp (second_r),
    .lane_smp   (lane_smp),
    .lane_key   (lane_key)
  );

  // compare-exchange network
  pss_sort_net #(
    .KEY_W (KEY_W)
  ) u_net (
    .key_in  (lane_key),
    .key_out (sort_key)
  );

  // decode sorted keys, idle slots read zero; with sort off the routed samples pass
  always_comb begin
    for (int i = 0; i < FIRST_LANES; i++) begin
      if (!cfg.sort_enable) begin
        res_nxt[i] = lane_smp[i];
      end else if (sort_key[i][SAMPLE_BITS]) begin
        res_nxt[i] = '0;
      end else begin
        res_nxt[i] = {~sort_key[i][SAMPLE_BITS-1], sort_key[i][SAMPLE_BITS-2:0]};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.out_0 = res_r[0];
  assign out_ch.out_1 = res_r[1];
  assign out_ch.out_2 = res_r[2];
  assign out_ch.out_3 = res_r[3];
  assign out_ch.out_4 = res_r[4];
  assign out_ch.out_5 = res_r[5];
  assign out_ch.out_6 = res_r[6];
  assign out_ch.out_7 = res_r[7];

endmodule
